// ===== hdl/tmm_pkg.sv =====
// Package with the types and constants of the tiled matrix multiplier.
package tmm_pkg;

   localparam int TILE_DEF      = 16;
   localparam int MAX_TILES_DEF = 4;
   localparam int SUM_W         = 40;
   localparam int VAL_W         = 16;
   localparam int IDX_W         = 6;
   localparam int TPS_W         = 3;

   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_ROW    = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_col;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic enable;
   } mac_ctl_type;

endpackage

// ===== hdl/tiled_matrix_multiply.sv =====
// Top level of the tiled matrix multiplier.
// Channel | Direction | Payload
// req     | in        | req_type: cmd, row, col, value
// rsp     | out       | rsp_type: out_col, sum, last
// csr     | in        | tiles_per_side
// A load is written when it is accepted. A row request streams k = 0..N-1 through the cell row,
// where the cell of column c sees A[row][k] after the A registers of the cells before it and
// reads B[k][c] from its own column memory. The first item leaves after the feed and flush
// states; the flush always covers the whole chain of the largest side, SIDE, whatever N is.
// Then N items leave one per cycle while rsp is ready. Reset sets the size to four tiles and
// leaves storage alone. A stall on rsp holds the drain, and req waits until the last item.
module tiled_matrix_multiply #(
   parameter int TILE      = tmm_pkg::TILE_DEF,
   parameter int MAX_TILES = tmm_pkg::MAX_TILES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tmm_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tmm_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tmm_pkg::TPS_W-1:0]   csr_data
);
   import tmm_pkg::*;

   localparam int SIDE  = TILE * MAX_TILES;
   localparam int SW    = $clog2(SIDE + 1);
   localparam int KW    = (SIDE > 1) ? $clog2(SIDE) : 1;
   localparam int AW    = (SIDE > 1) ? $clog2(SIDE * SIDE) : 1;
   localparam int LAT   = 4;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FEED  = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [TPS_W-1:0]   tps_ff;
   logic [SW-1:0]      side_len;
   logic [SW:0]        cnt_ff, cnt_in;
   logic [KW-1:0]      row_ff, row_in;
   logic               req_fire;
   logic               in_range;
   logic               feed;
   logic [KW-1:0]      k_idx;
   logic [AW-1:0]      a_wr_addr;
   logic [AW-1:0]      a_rd_addr;

   logic signed [VAL_W-1:0]       a_mem [SIDE*SIDE];
   logic signed [VAL_W-1:0]       a_rd_ff;
   logic signed [SIDE*VAL_W-1:0]  b_row;
   logic                          feed_ff;
   logic                          clr_ff;
   mac_ctl_type                   ctl;
   logic signed [SIDE*SUM_W-1:0]  acc_all;
   logic signed [SIDE*SUM_W-1:0]  out_ff;

   always_comb begin
      if (tps_ff == '0) begin
         side_len = SW'(TILE);
      end else if (32'(tps_ff) > MAX_TILES) begin
         side_len = SW'(SIDE);
      end else begin
         side_len = SW'(32'(tps_ff) * TILE);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign in_range  = (32'(req_data.row) < 32'(side_len))
                      && (32'(req_data.col) < 32'(side_len));
   assign feed      = (state_ff == ST_FEED);
   assign k_idx     = cnt_ff[KW-1:0];
   assign a_wr_addr = AW'(req_data.row[KW-1:0] * SIDE + req_data.col[KW-1:0]);
   assign a_rd_addr = AW'(row_ff * SIDE + k_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_W'(4);
      end else if (csr_valid) begin
         tps_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && in_range && req_data.cmd == CMD_LOAD_A) begin
         a_mem[a_wr_addr] <= req_data.value;
      end
      a_rd_ff <= a_mem[a_rd_addr];
   end

   for (genvar c = 0; c < SIDE; c++) begin : g_bcol
      logic signed [VAL_W-1:0] b_mem [SIDE];
      logic signed [VAL_W-1:0] b_rd_ff;
      logic [KW-1:0]           k_rd;
      if (c == 0) begin : g_k0
         assign k_rd = k_idx;
      end else begin : g_kdly
         logic [KW-1:0] k_dly_ff [c];
         always_ff @(posedge clock) begin
            k_dly_ff[0] <= k_idx;
            for (int j = 1; j < c; j++) begin
               k_dly_ff[j] <= k_dly_ff[j-1];
            end
         end
         assign k_rd = k_dly_ff[c-1];
      end
      always_ff @(posedge clock) begin
         if (req_fire && in_range && req_data.cmd == CMD_LOAD_B
             && req_data.col[KW-1:0] == KW'(c)) begin
            b_mem[req_data.row[KW-1:0]] <= req_data.value;
         end
         b_rd_ff <= b_mem[k_rd];
      end
      assign b_row[c*VAL_W +: VAL_W] = b_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_ff <= 1'b0;
         clr_ff  <= 1'b0;
      end else begin
         feed_ff <= feed;
         clr_ff  <= feed && (cnt_ff == '0);
      end
   end
   assign ctl.enable = feed_ff;
   assign ctl.clear  = clr_ff;

   tmm_array #(.SIDE(SIDE)) u_array (
      .clock  (clock),
      .ctl    (ctl),
      .a_in   (a_rd_ff),
      .b_row  (b_row),
      .acc_all(acc_all)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      row_in   = row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.cmd == CMD_ROW
                && 32'(req_data.row) < 32'(side_len)) begin
               state_in = ST_FEED;
               cnt_in   = '0;
               row_in   = req_data.row[KW-1:0];
            end
         end
         ST_FEED: begin
            if (cnt_ff == (SW+1)'(side_len - 1'b1)) begin
               state_in = ST_FLUSH;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (cnt_ff == (SW+1)'(SIDE + LAT)) begin
               state_in = ST_OUT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (cnt_ff == (SW+1)'(side_len - 1'b1)) begin
                  state_in = ST_IDLE;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FLUSH && state_in == ST_OUT) begin
         out_ff <= acc_all;
      end else if (state_ff == ST_OUT && rsp_ready) begin
         out_ff <= out_ff >> SUM_W;
      end
   end

   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_data.out_col = IDX_W'(cnt_ff);
   assign rsp_data.sum     = out_ff[SUM_W-1:0];
   assign rsp_data.last    = (cnt_ff == (SW+1)'(side_len - 1'b1));
endmodule

// ===== hdl/tmm_cell.sv =====
// One multiply-accumulate cell that passes its A operand on to its neighbor.
module tmm_cell (
   input  logic                            clock,
   input  tmm_pkg::mac_ctl_type            ctl,
   input  logic signed [tmm_pkg::VAL_W-1:0] a_in,
   input  logic signed [tmm_pkg::VAL_W-1:0] b_in,
   output logic signed [tmm_pkg::VAL_W-1:0] a_out,
   output logic signed [tmm_pkg::SUM_W-1:0] acc
);
   import tmm_pkg::*;

   logic signed [VAL_W-1:0]   a_ff;
   logic signed [VAL_W-1:0]   b_ff;
   logic                      en_ff;
   logic                      clr_ff;
   logic signed [2*VAL_W-1:0] prod_ff;
   logic                      pen_ff;
   logic                      pclr_ff;
   logic signed [SUM_W-1:0]   acc_ff;
   logic signed [SUM_W-1:0]   acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (pclr_ff) begin
         acc_in = '0;
      end
      if (pen_ff) begin
         acc_in = acc_in + SUM_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      en_ff   <= ctl.enable;
      clr_ff  <= ctl.clear;
      prod_ff <= a_ff * b_ff;
      pen_ff  <= en_ff;
      pclr_ff <= clr_ff;
      acc_ff  <= acc_in;
   end

   assign a_out = a_ff;
   assign acc   = acc_ff;
endmodule

// ===== hdl/tmm_array.sv =====
// Row of MAC cells with one column of C in each cell.
module tmm_array #(
   parameter int SIDE = 64
) (
   input  logic                                clock,
   input  tmm_pkg::mac_ctl_type                ctl,
   input  logic signed [tmm_pkg::VAL_W-1:0]    a_in,
   input  logic signed [SIDE*tmm_pkg::VAL_W-1:0] b_row,
   output logic signed [SIDE*tmm_pkg::SUM_W-1:0] acc_all
);
   import tmm_pkg::*;

   logic signed [VAL_W-1:0] a_chain [SIDE+1];
   mac_ctl_type             ctl_chain [SIDE+1];

   assign a_chain[0]   = a_in;
   assign ctl_chain[0] = ctl;

   for (genvar i = 0; i < SIDE; i++) begin : g_cell
      mac_ctl_type ctl_ff;
      tmm_cell u_cell (
         .clock(clock),
         .ctl  (ctl_chain[i]),
         .a_in (a_chain[i]),
         .b_in (b_row[i*VAL_W +: VAL_W]),
         .a_out(a_chain[i+1]),
         .acc  (acc_all[i*SUM_W +: SUM_W])
      );
      always_ff @(posedge clock) begin
         ctl_ff <= ctl_chain[i];
      end
      assign ctl_chain[i+1] = ctl_ff;
   end
endmodule
